// ===== rtl/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and codes for the linear-probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Fixed port field widths
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned KEY_IN_W   = 32;
  localparam int unsigned VAL_IN_W   = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_OUT_W = 8;
  localparam int unsigned OCC_OUT_W  = 9;
  localparam int unsigned MARK_W     = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_DUPLICATE = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

  typedef enum logic [MARK_W-1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;    // take the input beat
    logic hash;    // home slot computation
    logic probe;   // issue one slot read / examine one slot
    logic wr;      // commit insert or remove
    logic sweep;   // write one empty mark
    logic finish;  // load the output register
  } lpht_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic req_clear;
    logic hash_done;
    logic probe_done;
    logic need_write;
    logic sweep_last;
    logic out_free;
  } lpht_sts_t;

endpackage

// ===== rtl/lpht_ram.sv =====
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ===== rtl/lpht_datapath.sv =====
// ----------------------------------------------------------------------------
// lpht_datapath
// Slot memory, home slot unit, probe checker, result and output registers.
// ----------------------------------------------------------------------------
module lpht_datapath #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned KEY_W    = 32,
  parameter int unsigned VAL_W    = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lpht_pkg::lpht_cmd_t          cmd_i,
  output lpht_pkg::lpht_sts_t          sts_o,
  input  logic [lpht_pkg::FUNC_W-1:0]  func_i,
  input  logic [lpht_pkg::KEY_IN_W-1:0] key_in_i,
  input  logic [lpht_pkg::VAL_IN_W-1:0] value_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lpht_pkg::STATUS_W-1:0] status_o,
  output logic [lpht_pkg::VAL_IN_W-1:0] value_out_o,
  output logic [lpht_pkg::SLOT_OUT_W-1:0] slot_index_o,
  output logic [lpht_pkg::OCC_OUT_W-1:0] occupied_o
);
  import lpht_pkg::*;

  localparam int unsigned SW      = $clog2(CAPACITY);
  localparam int unsigned CW      = $clog2(CAPACITY + 1);
  localparam int unsigned WW      = MARK_W + KEY_W + VAL_W;
  localparam bit          CapPow2 = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam logic [SW-1:0] LastSlot = SW'(CAPACITY - 1);

  // Item registers
  func_e             func_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;

  // Probe state
  logic [SW-1:0]     addr_q, chk_q, pcnt_q, free_slot_q;
  logic              chk_vld_q, have_free_q;
  logic [SW-1:0]     home;

  // Results
  status_e           res_status_q;
  logic [VAL_W-1:0]  res_value_q;
  logic [SW-1:0]     res_slot_q, wr_slot_q;
  mark_e             wr_mark_q;

  logic [CW-1:0]     used_q;
  logic [SW-1:0]     sweep_q;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [VAL_IN_W-1:0] out_value_q;
  logic [SLOT_OUT_W-1:0] out_slot_q;
  logic [OCC_OUT_W-1:0]  out_occ_q;

  // RAM
  logic              ram_wr_en;
  logic [SW-1:0]     ram_wr_addr;
  logic [WW-1:0]     ram_wr_data, ram_rd_data;

  lpht_ram #(
    .WIDTH (WW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (cmd_i.probe),
    .rd_addr_i (addr_q),
    .rd_data_o (ram_rd_data)
  );

  assign ram_wr_en   = cmd_i.sweep | cmd_i.wr;
  assign ram_wr_addr = cmd_i.sweep ? sweep_q : wr_slot_q;
  assign ram_wr_data = cmd_i.sweep ? {MARK_EMPTY, {(KEY_W + VAL_W){1'b0}}}
                                   : {wr_mark_q, key_q, val_q};

  // Home slot
  if (CapPow2) begin : g_home_mask
    assign home              = SW'(key_q);
    assign sts_o.hash_done   = 1'b1;
  end else begin : g_home_mod
    // Reciprocal multiply, quotient times capacity, one correcting subtract
    localparam int unsigned      RecSh  = KEY_W + SW - 1;
    localparam int unsigned      XW     = KEY_W + SW;
    localparam logic [63:0]      Recip  = (64'd1 << RecSh) / 64'(CAPACITY);
    localparam logic [KEY_W-1:0] RecipK = Recip[KEY_W-1:0];
    localparam logic [XW-1:0]    CapX   = XW'(CAPACITY);
    logic [1:0]         hcnt_q;
    logic [2*KEY_W-1:0] prod_q, prod_sh;
    logic [XW-1:0]      qcap_q, diff;
    logic [SW-1:0]      rem_q;

    // quotient estimate is exact or one low
    assign prod_sh         = prod_q >> RecSh;
    assign diff            = XW'(key_q) - qcap_q;
    assign home            = rem_q;
    assign sts_o.hash_done = (hcnt_q == 2'd3);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hcnt_q <= '0;
      end else if (cmd_i.load) begin
        hcnt_q <= '0;
      end else if (cmd_i.hash && !sts_o.hash_done) begin
        hcnt_q <= hcnt_q + 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      prod_q <= (2*KEY_W)'(key_q) * (2*KEY_W)'(RecipK);
      qcap_q <= XW'(prod_sh[KEY_W-1:0]) * CapX;
      rem_q  <= (diff >= CapX) ? SW'(diff - CapX) : diff[SW-1:0];
    end
  end

  // Slot examine
  mark_e            rd_mark;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  logic             is_empty, is_hit, is_last, free_now, free_avail;
  logic [SW-1:0]    free_pick;
  logic             probe_done, need_write;
  status_e          nx_status;
  logic [VAL_W-1:0] nx_value;
  logic [SW-1:0]    nx_slot;
  mark_e            nx_mark;

  assign rd_mark    = mark_e'(ram_rd_data[WW-1 -: MARK_W]);
  assign rd_key     = ram_rd_data[VAL_W +: KEY_W];
  assign rd_val     = ram_rd_data[VAL_W-1:0];
  assign is_empty   = (rd_mark == MARK_EMPTY);
  assign is_hit     = (rd_mark == MARK_USED) && (rd_key == key_q);
  assign is_last    = (pcnt_q == LastSlot);
  // A deleted (or unknown) mark is a reuse candidate for insert
  assign free_now   = (func_q == FUNC_INSERT) && !have_free_q && !is_empty
                      && (rd_mark != MARK_USED);
  assign free_avail = have_free_q || is_empty || free_now;
  assign free_pick  = have_free_q ? free_slot_q : chk_q;
  assign probe_done = chk_vld_q && (is_empty || is_hit || is_last);

  always_comb begin
    nx_status  = STS_NOT_FOUND;
    nx_value   = '0;
    nx_slot    = '0;
    nx_mark    = MARK_USED;
    need_write = 1'b0;
    if (is_hit) begin
      nx_slot = chk_q;
      case (func_q)
        FUNC_LOOKUP: begin
          nx_status = STS_OK;
          nx_value  = rd_val;
        end
        FUNC_REMOVE: begin
          nx_status  = STS_OK;
          nx_mark    = MARK_DELETED;
          need_write = 1'b1;
        end
        FUNC_INSERT: nx_status = STS_DUPLICATE;
        default:     nx_status = STS_OK;
      endcase
    end else if (func_q == FUNC_INSERT) begin
      if (free_avail) begin
        nx_status  = STS_OK;
        nx_slot    = free_pick;
        need_write = 1'b1;
      end else begin
        nx_status = STS_FULL;
      end
    end
  end

  assign sts_o.probe_done = probe_done;
  assign sts_o.need_write = need_write;
  assign sts_o.req_clear  = (func_e'(func_i) == FUNC_CLEAR);
  assign sts_o.sweep_last = (sweep_q == LastSlot);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_vld_q   <= 1'b0;
      have_free_q <= 1'b0;
      pcnt_q      <= '0;
      used_q      <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        chk_vld_q   <= 1'b0;
        have_free_q <= 1'b0;
        pcnt_q      <= '0;
      end else if (cmd_i.probe) begin
        chk_vld_q <= 1'b1;
        if (chk_vld_q) begin
          pcnt_q <= pcnt_q + 1'b1;
          if (free_now) begin
            have_free_q <= 1'b1;
          end
        end
      end
      if (cmd_i.sweep) begin
        used_q  <= '0;
        sweep_q <= sts_o.sweep_last ? '0 : sweep_q + 1'b1;
      end else if (cmd_i.wr) begin
        if (func_q == FUNC_INSERT) begin
          used_q <= used_q + 1'b1;
        end else if (used_q != '0) begin
          used_q <= used_q - 1'b1;
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic [SW+SLOT_OUT_W-1:0] slot_ext;
  logic [CW+OCC_OUT_W-1:0]  occ_ext;
  assign slot_ext = {{SLOT_OUT_W{1'b0}}, res_slot_q};
  assign occ_ext  = {{OCC_OUT_W{1'b0}}, used_q};

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q       <= func_e'(func_i);
      key_q        <= key_in_i[KEY_W-1:0];
      val_q        <= value_in_i[VAL_W-1:0];
      res_status_q <= STS_OK;
      res_value_q  <= '0;
      res_slot_q   <= '0;
    end
    if (cmd_i.hash && sts_o.hash_done) begin
      addr_q <= home;
    end else if (cmd_i.probe) begin
      addr_q <= (addr_q == LastSlot) ? '0 : addr_q + 1'b1;
      chk_q  <= addr_q;
    end
    if (cmd_i.probe && chk_vld_q && free_now) begin
      free_slot_q <= chk_q;
    end
    if (cmd_i.probe && probe_done) begin
      res_status_q <= nx_status;
      res_value_q  <= nx_value;
      res_slot_q   <= nx_slot;
      wr_slot_q    <= nx_slot;
      wr_mark_q    <= nx_mark;
    end
    if (cmd_i.finish) begin
      out_status_q <= res_status_q;
      out_value_q  <= VAL_IN_W'(res_value_q);
      out_slot_q   <= slot_ext[SLOT_OUT_W-1:0];
      out_occ_q    <= occ_ext[OCC_OUT_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign value_out_o  = out_value_q;
  assign slot_index_o = out_slot_q;
  assign occupied_o   = out_occ_q;

  // Checks
  default disable iff (!rst_ni);

  a_used_bound: assert property (@(posedge clk_i) used_q <= CW'(CAPACITY))
    else $error("used count above capacity");
  a_port_clash: assert property (@(posedge clk_i) !(ram_wr_en && cmd_i.probe))
    else $error("slot write during probe");
  a_remove_used: assert property (@(posedge clk_i)
      cmd_i.wr && func_q == FUNC_REMOVE |-> used_q != '0)
    else $error("remove commit with no used slot");
  a_finish_out: assert property (@(posedge clk_i) cmd_i.finish |=> out_valid_q)
    else $error("result beat not presented");

endmodule

// ===== rtl/lpht_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: reset sweep, accept, home slot, probe, commit or clear sweep, result.
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpht_pkg::lpht_sts_t sts_i,
  output lpht_pkg::lpht_cmd_t cmd_o
);
  import lpht_pkg::*;

  typedef enum logic [6:0] {
    ST_INIT  = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_HASH  = 7'b0000100,
    ST_PROBE = 7'b0001000,
    ST_WRITE = 7'b0010000,
    ST_CLEAR = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.req_clear ? ST_CLEAR : ST_HASH;
        end
      end
      ST_HASH: begin
        cmd_o.hash = 1'b1;
        if (sts_i.hash_done) begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd_o.probe = 1'b1;
        if (sts_i.probe_done) begin
          state_d = sts_i.need_write ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = ST_DONE;
      end
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  default disable iff (!rst_ni);

  a_probe_exit: assert property (@(posedge clk_i)
      state_q == ST_PROBE && sts_i.probe_done |=> state_q == ST_WRITE || state_q == ST_DONE)
    else $error("probe finished without commit or result");
  a_load_idle: assert property (@(posedge clk_i) cmd_o.load |=> in_stall_o)
    else $error("second beat taken while busy");
  a_finish_free: assert property (@(posedge clk_i) cmd_o.finish |-> sts_i.out_free)
    else $error("result overwrote a waiting beat");

endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/value table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// Takes one operation (lookup, insert, remove, clear) at a time and returns one
// result beat per operation. Slots live in a single RAM with one read and one
// write port; probing reads one slot per cycle from the home slot (key mod
// CAPACITY, a mask when CAPACITY is a power of two). An insert or remove that
// writes commits its slot after the probe; with a non-power-of-two capacity the
// home slot is computed through registered multiply and subtract steps. Clear
// writes every slot. After reset the block writes an empty mark to every slot
// with in_stall_o high. A finished result waits in the output register while
// the next operation is taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lpht_pkg::FUNC_W-1:0]      func_i,
  input  logic [lpht_pkg::KEY_IN_W-1:0]    key_in_i,
  input  logic [lpht_pkg::VAL_IN_W-1:0]    value_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [lpht_pkg::STATUS_W-1:0]    status_o,
  output logic [lpht_pkg::VAL_IN_W-1:0]    value_out_o,
  output logic [lpht_pkg::SLOT_OUT_W-1:0]  slot_index_o,
  output logic [lpht_pkg::OCC_OUT_W-1:0]   occupied_o
);
  import lpht_pkg::*;

  // Keys and values arrive on 32-bit fields
  localparam int unsigned KeyW = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  localparam int unsigned ValW = (VALUE_BITS < VAL_IN_W) ? VALUE_BITS : VAL_IN_W;

  lpht_cmd_t cmd;
  lpht_sts_t sts;

  lpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lpht_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_W    (KeyW),
    .VAL_W    (ValW)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (func_i),
    .key_in_i     (key_in_i),
    .value_in_i   (value_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .value_out_o  (value_out_o),
    .slot_index_o (slot_index_o),
    .occupied_o   (occupied_o)
  );

endmodule

// ===== bench/linear_probe_hash_table_tb.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_tb
// Self-checking bench for the linear-probe hash table.
// ----------------------------------------------------------------------------
// A queue of operations is filled up front and fed to the table by a
// randomly idling driver, while the result side stalls at random. A
// behavioral copy of the table (slots, marks and used count) computes the
// expected answer for every accepted operation. Each result beat is checked
// field by field against that answer. Directed operations cover hits, misses,
// wrap-around and tombstone reuse. A fill phase drives the table full. Random
// operations on clustered home slots then build long probe chains.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_tb;
  import lpht_pkg::*;

  localparam int unsigned SLOTS       = 256;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 300;   // longer than a clear pass
  localparam int unsigned LONG_HOLD   = 80;

  typedef struct {
    func_e       func;
    logic [31:0] key;
    logic [31:0] value;
    int unsigned gap;
    bit          drain;   // wait for all results before offering this beat
  } op_t;

  typedef struct {
    status_e     status;
    logic [31:0] value;
    logic [7:0]  slot;
    logic [8:0]  occ;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  func_e       func = FUNC_LOOKUP;
  logic [31:0] key_in = '0;
  logic [31:0] value_in = '0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] value_out_o;
  logic [7:0]  slot_index_o;
  logic [8:0]  occupied_o;

  op_t         pending_ops[$];
  answer_t     expected_answers[$];

  // behavioral copy of the table
  logic [31:0] shadow_key [SLOTS];
  logic [31:0] shadow_val [SLOTS];
  mark_e       shadow_mark [SLOTS];
  int unsigned shadow_used = 0;

  bit          beat_in = 1'b0;
  bit          beat_out = 1'b0;
  bit          offering = 1'b0;
  bit          idle_mode = 1'b0;
  int unsigned waited = 0;
  int unsigned wait_left = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned op_count [4] = '{0, 0, 0, 0};
  int unsigned status_seen [4] = '{0, 0, 0, 0};

  linear_probe_hash_table DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .func_i      (func),
    .key_in_i    (key_in),
    .value_in_i  (value_in),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .status_o    (status_o),
    .value_out_o (value_out_o),
    .slot_index_o(slot_index_o),
    .occupied_o  (occupied_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one operation to the shadow table and returns its answer.
  function automatic answer_t hash_apply(func_e f, logic [31:0] k, logic [31:0] v);
    answer_t     a;
    int unsigned s;
    int unsigned free_slot;
    bit          found;
    bit          have_free;
    a.status  = STS_OK;
    a.value   = '0;
    a.slot    = '0;
    s         = k % SLOTS;
    free_slot = 0;
    found     = 1'b0;
    have_free = 1'b0;
    case (f)
      FUNC_LOOKUP, FUNC_REMOVE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_mark[s] == MARK_EMPTY) break;
          if (shadow_mark[s] == MARK_USED && shadow_key[s] == k) begin
            found = 1'b1;
            break;
          end
          s = (s + 1) % SLOTS;
        end
        if (!found) begin
          a.status = STS_NOT_FOUND;
        end else begin
          a.slot = s[7:0];
          if (f == FUNC_LOOKUP) begin
            a.value = shadow_val[s];
          end else begin
            shadow_mark[s] = MARK_DELETED;
            if (shadow_used > 0) shadow_used--;
          end
        end
      end
      FUNC_INSERT: begin
        // key must be proven absent before a tombstone is reused
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_mark[s] == MARK_EMPTY) begin
            if (!have_free) begin
              have_free = 1'b1;
              free_slot = s;
            end
            break;
          end
          if (shadow_mark[s] == MARK_USED) begin
            if (shadow_key[s] == k) begin
              found = 1'b1;
              break;
            end
          end else if (!have_free) begin
            have_free = 1'b1;
            free_slot = s;
          end
          s = (s + 1) % SLOTS;
        end
        if (found) begin
          a.status = STS_DUPLICATE;
          a.slot   = s[7:0];
        end else if (!have_free) begin
          a.status = STS_FULL;
        end else begin
          shadow_key[free_slot]  = k;
          shadow_val[free_slot]  = v;
          shadow_mark[free_slot] = MARK_USED;
          shadow_used++;
          a.slot = free_slot[7:0];
        end
      end
      default: begin
        foreach (shadow_mark[i]) shadow_mark[i] = MARK_EMPTY;
        shadow_used = 0;
      end
    endcase
    a.occ = 9'(shadow_used);
    return a;
  endfunction

  function automatic void queue_op(func_e f, logic [31:0] k, logic [31:0] v, bit drain);
    op_t o;
    if ($urandom_range(0, 39) == 0) idle_mode = !idle_mode;
    o.func  = f;
    o.key   = k;
    o.value = v;
    o.gap   = idle_mode ? $urandom_range(0, 5) : 0;
    o.drain = drain;
    pending_ops.push_back(o);
  endfunction

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
             results_seen, field, want, got);
  endtask

  // sample at the rising edge: predict accepted beats, check result beats
  always @(posedge clk_i) begin
    answer_t a;
    if (rst_ni) begin
      cycles++;
      beat_in  = in_valid && !in_stall_o;
      beat_out = out_valid_o && !out_stall;
      if (beat_in) begin
        expected_answers.push_back(hash_apply(func, key_in, value_in));
        op_count[func]++;
      end
      if (beat_out) begin
        results_seen++;
        status_seen[status_o]++;
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected beat, status", '0, 32'(status_o));
        end else begin
          a = expected_answers.pop_front();
          if (status_o != a.status)
            report_mismatch("status", 32'(a.status), 32'(status_o));
          if (value_out_o != a.value)
            report_mismatch("value_out", a.value, value_out_o);
          if (slot_index_o != a.slot)
            report_mismatch("slot_index", 32'(a.slot), 32'(slot_index_o));
          if (occupied_o != a.occ)
            report_mismatch("occupied", 32'(a.occ), 32'(occupied_o));
        end
      end
    end
  end

  // input side: drive at the falling edge from the pending queue
  always @(negedge clk_i) begin
    op_t nxt;
    if (rst_ni) begin
      if (offering && beat_in) offering = 1'b0;
      if (!offering && pending_ops.size() != 0) begin
        if (waited < pending_ops[0].gap) begin
          waited++;
        end else if (!pending_ops[0].drain || expected_answers.size() == 0) begin
          nxt = pending_ops.pop_front();
          func     <= nxt.func;
          key_in   <= nxt.key;
          value_in <= nxt.value;
          offering = 1'b1;
          waited   = 0;
        end
      end
      in_valid <= offering;
    end
  end

  // result side: random stall after beats while bit 6 of the result count is set, plus a couple of long holds
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (beat_out) begin
        wait_left = results_seen[6] ? $urandom_range(0, 5) : 0;
        if (results_seen == 150 || results_seen == 600) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("linear_probe_hash_table_tb failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] hot_keys[$];
    logic [31:0] k;
    int unsigned base;
    int unsigned width;
    int unsigned pick;
    foreach (shadow_mark[i]) shadow_mark[i] = MARK_EMPTY;

    // directed: misses on an empty table, collisions, wrap, tombstones
    queue_op(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_op(FUNC_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_op(FUNC_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    queue_op(FUNC_INSERT, 32'h0000_0100, 32'h0000_0000, 1'b0);
    queue_op(FUNC_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b0);
    queue_op(FUNC_INSERT, 32'hFFFF_FEFF, 32'h5A5A_5A5A, 1'b0);
    queue_op(FUNC_INSERT, 32'h0000_0000, 32'h1234_5678, 1'b0);
    queue_op(FUNC_LOOKUP, 32'h0000_0100, 32'h0, 1'b0);
    queue_op(FUNC_LOOKUP, 32'hFFFF_FEFF, 32'h0, 1'b0);
    queue_op(FUNC_REMOVE, 32'h0000_0000, 32'h0, 1'b0);
    queue_op(FUNC_LOOKUP, 32'h0000_0100, 32'h0, 1'b0);
    queue_op(FUNC_LOOKUP, 32'h0000_0000, 32'h0, 1'b0);
    queue_op(FUNC_REMOVE, 32'h0000_0000, 32'h0, 1'b0);
    queue_op(FUNC_INSERT, 32'h0000_0100, 32'hDEAD_BEEF, 1'b0);
    queue_op(FUNC_INSERT, 32'h0000_0200, 32'hCAFE_F00D, 1'b0);
    queue_op(FUNC_LOOKUP, 32'h0000_0200, 32'h0, 1'b0);
    queue_op(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_op(FUNC_LOOKUP, 32'h0000_0100, 32'h0, 1'b0);
    queue_op(FUNC_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    queue_op(FUNC_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    queue_op(FUNC_LOOKUP, 32'hAAAA_AAAA, 32'h0, 1'b0);

    // fill every slot with keys homed around the wrap point
    queue_op(FUNC_CLEAR, $urandom, $urandom, 1'b1);
    for (int i = 0; i < SLOTS; i++) begin
      k = $urandom;
      k[23:8] = 16'(i);
      k[7:0]  = 8'(240 + $urandom_range(0, 31));
      hot_keys.push_back(k);
      queue_op(FUNC_INSERT, k, $urandom, 1'b0);
    end
    k = $urandom;
    k[23:8] = 16'hFFFF;
    queue_op(FUNC_INSERT, k, $urandom, 1'b1);          // table full
    queue_op(FUNC_INSERT, hot_keys[5], $urandom, 1'b0); // duplicate in a full table
    queue_op(FUNC_LOOKUP, k, $urandom, 1'b0);           // miss after a full scan
    queue_op(FUNC_REMOVE, hot_keys[0], $urandom, 1'b0);
    queue_op(FUNC_REMOVE, hot_keys[100], $urandom, 1'b0);
    queue_op(FUNC_REMOVE, hot_keys[255], $urandom, 1'b0);
    queue_op(FUNC_LOOKUP, k, $urandom, 1'b0);           // no empty slot left to stop on
    queue_op(FUNC_REMOVE, hot_keys[0], $urandom, 1'b0);
    for (int i = 0; i < 4; i++) begin
      k = $urandom;
      k[23:8] = 16'(16'hF000 + i);
      queue_op(FUNC_INSERT, k, $urandom, 1'b0);        // three reuse tombstones, then full
    end
    queue_op(FUNC_LOOKUP, hot_keys[100], $urandom, 1'b0);
    queue_op(FUNC_LOOKUP, hot_keys[200], $urandom, 1'b0);
    queue_op(FUNC_CLEAR, $urandom, $urandom, 1'b0);
    hot_keys.delete();

    // random traffic on clustered home slots
    for (int c = 0; c < 12; c++) begin
      base  = $urandom_range(0, SLOTS - 1);
      width = $urandom_range(1, 24);
      if ($urandom_range(0, 2) == 0) begin
        queue_op(FUNC_CLEAR, $urandom, $urandom, 1'b0);
        hot_keys.delete();
      end
      repeat (48) begin
        pick = $urandom_range(0, 99);
        if (hot_keys.size() != 0 && $urandom_range(0, 9) < 6) begin
          k = hot_keys[$urandom_range(0, hot_keys.size() - 1)];
        end else begin
          k = $urandom;
          if ($urandom_range(0, 4) != 0) k[7:0] = 8'(base + $urandom_range(0, width - 1));
        end
        if (pick < 40) begin
          queue_op(FUNC_INSERT, k, $urandom, $urandom_range(0, 99) == 0);
          hot_keys.push_back(k);
        end else if (pick < 75) begin
          queue_op(FUNC_LOOKUP, k, $urandom, $urandom_range(0, 99) == 0);
        end else if (pick < 97) begin
          queue_op(FUNC_REMOVE, k, $urandom, $urandom_range(0, 99) == 0);
        end else begin
          queue_op(FUNC_CLEAR, k, $urandom, 1'b0);
          hot_keys.delete();
        end
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_ops.size() == 0 && !offering && expected_answers.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d operations: %0d lookup, %0d insert, %0d remove, %0d clear",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[FUNC_LOOKUP], op_count[FUNC_INSERT], op_count[FUNC_REMOVE],
             op_count[FUNC_CLEAR]);
    $display("answers seen: %0d ok, %0d not found, %0d duplicate, %0d full; %0d mismatches",
             status_seen[STS_OK], status_seen[STS_NOT_FOUND], status_seen[STS_DUPLICATE],
             status_seen[STS_FULL], mismatches);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("linear_probe_hash_table_tb passed");
    end else begin
      $display("linear_probe_hash_table_tb failed");
    end
    $finish;
  end

endmodule
